// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file itra_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ITRA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("itra checker: property violated");

// A condition that must be followed by another in the next cycle.
`define ITRA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("itra checker: sequence violated");

`endif

// ----- rtl/core/itra_pkg.sv -----
package itra_pkg;

    localparam int VALUE_W     = 32;
    localparam int BASE_W      = 5;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int REM_W       = DIGIT_W + 1;
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int DIGIT_IDX_W = $clog2(VALUE_W);
    localparam int DIGIT_CNT_W = $clog2(VALUE_W + 1);

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
    localparam logic [BASE_W-1:0] BASE_HEX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_F     = 8'h66;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PRE_ZERO,
        S_PRE_X,
        S_MINUS,
        S_FETCH,
        S_PUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_X,
        SEL_MINUS,
        SEL_DIGIT
    } char_sel_t;

    typedef struct packed {
        logic      accept;
        logic      div_step;
        logic      put;
        char_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic bad_base;
        logic ptr;
        logic neg;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < DIGIT_W'(10))
        begin
            return CHAR_ZERO + ext;
        end
        return CHAR_A - CHAR_W'(10) + ext;
    endfunction

endpackage

// ----- rtl/core/itra_in_if.sv -----
interface itra_in_if;
    logic                             valid;
    logic                             ready;
    logic [itra_pkg::VALUE_W-1:0]     value;
    logic [itra_pkg::BASE_W-1:0]      base;
    logic                             is_signed;
    logic                             pointer_mode;

    modport source (output valid, value, base, is_signed, pointer_mode, input ready);
    modport sink   (input valid, value, base, is_signed, pointer_mode, output ready);
endinterface

// ----- rtl/core/itra_out_if.sv -----
interface itra_out_if;
    logic                        valid;
    logic                        ready;
    logic [itra_pkg::CHAR_W-1:0] char_out;
    logic                        last;

    modport source (output valid, char_out, last, input ready);
    modport sink   (input valid, char_out, last, output ready);
endinterface

// ----- rtl/core/itra_ctrl.sv -----
module itra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  itra_pkg::status_t st,
    input  logic              last_digit,
    output itra_pkg::cmd_t    cmd
);

    itra_pkg::state_t state_reg;
    itra_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itra_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itra_pkg::S_IDLE:
            begin
                if (in_valid && !st.bad_base)
                begin
                    state_next = itra_pkg::S_DIV;
                end
            end
            itra_pkg::S_DIV:
            begin
                if (st.div_done)
                begin
                    if (st.ptr)
                    begin
                        state_next = itra_pkg::S_PRE_ZERO;
                    end
                    else if (st.neg)
                    begin
                        state_next = itra_pkg::S_MINUS;
                    end
                    else
                    begin
                        state_next = itra_pkg::S_FETCH;
                    end
                end
            end
            itra_pkg::S_PRE_ZERO:
            begin
                if (st.out_free)
                begin
                    state_next = itra_pkg::S_PRE_X;
                end
            end
            itra_pkg::S_PRE_X, itra_pkg::S_MINUS:
            begin
                if (st.out_free)
                begin
                    state_next = itra_pkg::S_FETCH;
                end
            end
            itra_pkg::S_FETCH:
            begin
                state_next = itra_pkg::S_PUT;
            end
            itra_pkg::S_PUT:
            begin
                if (st.out_free)
                begin
                    state_next = last_digit ? itra_pkg::S_IDLE : itra_pkg::S_FETCH;
                end
            end
            default:
            begin
                state_next = itra_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = itra_pkg::SEL_DIGIT;
        unique case (state_reg)
            itra_pkg::S_IDLE:
            begin
                cmd.accept = 1'b1;
            end
            itra_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            itra_pkg::S_PRE_ZERO:
            begin
                cmd.sel = itra_pkg::SEL_ZERO;
                cmd.put = st.out_free;
            end
            itra_pkg::S_PRE_X:
            begin
                cmd.sel = itra_pkg::SEL_X;
                cmd.put = st.out_free;
            end
            itra_pkg::S_MINUS:
            begin
                cmd.sel = itra_pkg::SEL_MINUS;
                cmd.put = st.out_free;
            end
            itra_pkg::S_FETCH:
            begin
                cmd.put = 1'b0;
            end
            itra_pkg::S_PUT:
            begin
                cmd.put = st.out_free;
            end
            default:
            begin
                cmd.put = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/itra_dp.sv -----
module itra_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  itra_pkg::cmd_t                  cmd,
    output itra_pkg::status_t               st,
    output logic                            last_digit,
    input  logic                            in_valid,
    input  logic [itra_pkg::VALUE_W-1:0]    value,
    input  logic [itra_pkg::BASE_W-1:0]     base,
    input  logic                            is_signed,
    input  logic                            pointer_mode,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [itra_pkg::CHAR_W-1:0]     char_out,
    output logic                            last
);

    logic [itra_pkg::VALUE_W-1:0]     q_reg;
    logic [itra_pkg::REM_W-1:0]       r_reg;
    logic [itra_pkg::BASE_W-1:0]      base_reg;
    logic [itra_pkg::STEP_CNT_W-1:0]  step_reg;
    logic [itra_pkg::DIGIT_CNT_W-1:0] cnt_reg;
    logic                             ptr_reg;
    logic                             neg_reg;
    logic [itra_pkg::DIGIT_W-1:0]     rdata_reg;
    logic                             out_valid_reg;
    logic [itra_pkg::CHAR_W-1:0]      out_char_reg;
    logic                             out_last_reg;

    logic [itra_pkg::DIGIT_W-1:0]     digit_mem [itra_pkg::VALUE_W];

    logic [itra_pkg::VALUE_W-1:0]     q_step;
    logic [itra_pkg::REM_W-1:0]       r_step;
    logic                             load;
    logic                             in_neg;
    logic                             div_last;
    logic                             out_free;
    logic [itra_pkg::DIGIT_CNT_W-1:0] cnt_dec;
    logic [itra_pkg::DIGIT_IDX_W-1:0] rd_idx;
    logic [itra_pkg::CHAR_W-1:0]      put_char;
    logic                             put_last;

    assign load     = cmd.accept && in_valid;
    assign in_neg   = is_signed && !pointer_mode && value[itra_pkg::VALUE_W-1];
    assign div_last = (step_reg == itra_pkg::STEP_CNT_W'(itra_pkg::DIV_STEPS - 1));
    assign out_free = !out_valid_reg || out_ready;
    assign cnt_dec  = cnt_reg - itra_pkg::DIGIT_CNT_W'(1);
    assign rd_idx   = cnt_dec[itra_pkg::DIGIT_IDX_W-1:0];

    assign last_digit  = (cnt_reg == itra_pkg::DIGIT_CNT_W'(1));
    assign st.bad_base = !pointer_mode
                         && ((base < itra_pkg::BASE_MIN) || (base > itra_pkg::BASE_MAX));
    assign st.ptr      = ptr_reg;
    assign st.neg      = neg_reg;
    assign st.div_done = div_last && (q_step == '0);
    assign st.out_free = out_free;

    // Restoring division of the quotient register by the base, several bits a cycle.
    always_comb
    begin
        logic [itra_pkg::REM_W-1:0]   r;
        logic [itra_pkg::VALUE_W-1:0] q;
        logic [itra_pkg::REM_W-1:0]   t;
        r = r_reg;
        q = q_reg;
        for (int i = 0; i < itra_pkg::STEP_BITS; i++)
        begin
            t = {r[itra_pkg::REM_W-2:0], q[itra_pkg::VALUE_W-1]};
            q = {q[itra_pkg::VALUE_W-2:0], 1'b0};
            if (t >= base_reg)
            begin
                r    = t - base_reg;
                q[0] = 1'b1;
            end
            else
            begin
                r = t;
            end
        end
        q_step = q;
        r_step = r;
    end

    always_comb
    begin
        put_last = 1'b0;
        case (cmd.sel)
            itra_pkg::SEL_ZERO:  put_char = itra_pkg::CHAR_ZERO;
            itra_pkg::SEL_X:     put_char = itra_pkg::CHAR_X;
            itra_pkg::SEL_MINUS: put_char = itra_pkg::CHAR_MINUS;
            default:
            begin
                put_char = itra_pkg::digit_char(rdata_reg);
                put_last = last_digit;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                step_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                if (div_last)
                begin
                    step_reg <= '0;
                    cnt_reg  <= cnt_reg + itra_pkg::DIGIT_CNT_W'(1);
                end
                else
                begin
                    step_reg <= step_reg + itra_pkg::STEP_CNT_W'(1);
                end
            end
            else if (cmd.put && (cmd.sel == itra_pkg::SEL_DIGIT))
            begin
                cnt_reg <= cnt_dec;
            end

            if (cmd.put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg    <= in_neg ? (~value + itra_pkg::VALUE_W'(1)) : value;
            r_reg    <= '0;
            base_reg <= pointer_mode ? itra_pkg::BASE_HEX : base;
            ptr_reg  <= pointer_mode;
            neg_reg  <= in_neg;
        end
        else if (cmd.div_step)
        begin
            q_reg <= q_step;
            r_reg <= div_last ? '0 : r_step;
        end
        if (cmd.put)
        begin
            out_char_reg <= put_char;
            out_last_reg <= put_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && div_last)
        begin
            digit_mem[cnt_reg[itra_pkg::DIGIT_IDX_W-1:0]] <= r_step[itra_pkg::DIGIT_W-1:0];
        end
        rdata_reg <= digit_mem[rd_idx];
    end

    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign last      = out_last_reg;

endmodule

// ----- rtl/core/integer_to_radix_ascii.sv -----
// Converts one 32-bit word on number into its text in base 2 to 16 on text, one lower-case
// ASCII character per word, most significant digit first, with a leading '-' for negative
// values in signed mode and "0x" in pointer mode; the final character carries last, and
// outside pointer mode a base outside 2..16 is consumed without any text. A word is taken only
// while the block is idle. The divider retires 8 quotient bits per cycle, so each digit takes
// a full pass over the 32-bit quotient; the digits are then read back from a small digit
// memory with registered read, through a fetch state and a put state per digit, and each
// prefix character has its own state. A stall on text holds the block in those output states.
module integer_to_radix_ascii (
    input  logic        clk,
    input  logic        rst_n,
    itra_in_if.sink     number,
    itra_out_if.source  text
);

    itra_pkg::cmd_t    cmd;
    itra_pkg::status_t st;
    logic              last_digit;

    itra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (number.valid),
        .st         (st),
        .last_digit (last_digit),
        .cmd        (cmd)
    );

    itra_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .last_digit   (last_digit),
        .in_valid     (number.valid),
        .value        (number.value),
        .base         (number.base),
        .is_signed    (number.is_signed),
        .pointer_mode (number.pointer_mode),
        .out_ready    (text.ready),
        .out_valid    (text.valid),
        .char_out     (text.char_out),
        .last         (text.last)
    );

    assign number.ready = cmd.accept;

endmodule

// ----- rtl/core/itra_checker.sv -----
`include "assert_macros.svh"

module itra_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        number_valid,
    input  logic                        number_ready,
    input  logic                        text_valid,
    input  logic                        text_ready,
    input  logic [itra_pkg::CHAR_W-1:0] text_char,
    input  logic                        text_last
);

    // A stalled word keeps its character and mark.
    `ITRA_ASSERT_NEXT(a_text_hold, text_valid && !text_ready, text_valid && $stable(text_char) && $stable(text_last))

    // Only digits, the minus sign and the hex marker ever appear.
    `ITRA_ASSERT(a_char_legal, text_valid |-> ((text_char >= itra_pkg::CHAR_ZERO && text_char <= itra_pkg::CHAR_NINE) || (text_char >= itra_pkg::CHAR_A && text_char <= itra_pkg::CHAR_F) || text_char == itra_pkg::CHAR_X || text_char == itra_pkg::CHAR_MINUS))

    // A prefix character is never the end of a value's text.
    `ITRA_ASSERT(a_prefix_not_last, (text_valid && (text_char == itra_pkg::CHAR_X || text_char == itra_pkg::CHAR_MINUS)) |-> !text_last)

    // While a value's text is unfinished, no new value is taken.
    `ITRA_ASSERT(a_no_overlap, (text_valid && !text_last) |-> !number_ready)

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .number_valid (number.valid),
    .number_ready (number.ready),
    .text_valid   (text.valid),
    .text_ready   (text.ready),
    .text_char    (text.char_out),
    .text_last    (text.last)
);

// ----- tb/sv/integer_to_radix_ascii_test.sv -----
`timescale 1ns / 1ps

module integer_to_radix_ascii_test;

    typedef struct {
        logic [itra_pkg::VALUE_W-1:0] value;
        logic [itra_pkg::BASE_W-1:0]  base;
        logic                         sgn;
        logic                         ptr;
    } number_word_t;

    typedef struct {
        logic [itra_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    logic clk;
    logic rst_n;

    itra_in_if  number_if();
    itra_out_if text_if();

    integer_to_radix_ascii uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .text   (text_if)
    );

    number_word_t pending_numbers[$];
    text_char_t   expected_text[$];
    number_word_t next_word;
    text_char_t   oldest_char;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  mismatches;
    int  words_taken;
    int  silent_words;
    int  pointer_words;
    int  chars_checked;
    int  text_chars;
    bit  hold_go;
    logic hold_text;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch, %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int predict_text(input number_word_t w);
        logic [itra_pkg::VALUE_W-1:0] mag;
        logic [itra_pkg::VALUE_W-1:0] radix;
        logic [itra_pkg::DIGIT_W-1:0] digit;
        logic [itra_pkg::CHAR_W-1:0]  chars[$];
        logic [itra_pkg::CHAR_W-1:0]  digits[$];
        logic                         neg;
        text_char_t                   tc;
        neg = 1'b0;
        if (w.ptr)
        begin
            radix = itra_pkg::VALUE_W'(itra_pkg::BASE_HEX);
            chars.push_back(itra_pkg::CHAR_ZERO);
            chars.push_back(itra_pkg::CHAR_X);
        end
        else
        begin
            if (w.base < itra_pkg::BASE_MIN || w.base > itra_pkg::BASE_MAX)
            begin
                return 0;
            end
            radix = itra_pkg::VALUE_W'(w.base);
            neg = w.sgn && w.value[itra_pkg::VALUE_W-1];
        end
        mag = neg ? -w.value : w.value;
        do
        begin
            digit = itra_pkg::DIGIT_W'(mag % radix);
            if (digit < itra_pkg::DIGIT_W'(10))
            begin
                digits.push_front(itra_pkg::CHAR_ZERO + itra_pkg::CHAR_W'(digit));
            end
            else
            begin
                digits.push_front(itra_pkg::CHAR_A - itra_pkg::CHAR_W'(10)
                                  + itra_pkg::CHAR_W'(digit));
            end
            mag = mag / radix;
        end
        while (mag != 0);
        if (neg)
        begin
            chars.push_back(itra_pkg::CHAR_MINUS);
        end
        foreach (digits[i])
        begin
            chars.push_back(digits[i]);
        end
        foreach (chars[i])
        begin
            tc.ch = chars[i];
            tc.last = (i == chars.size() - 1);
            expected_text.push_back(tc);
        end
        return chars.size();
    endfunction

    task automatic queue_number(input logic [itra_pkg::VALUE_W-1:0] value,
                                input logic [itra_pkg::BASE_W-1:0] base,
                                input logic sgn, input logic ptr);
        number_word_t w;
        w.value = value;
        w.base = base;
        w.sgn = sgn;
        w.ptr = ptr;
        pending_numbers.push_back(w);
    endtask

    task automatic queue_random_numbers(input int count);
        int made;
        logic [itra_pkg::VALUE_W-1:0] value;
        logic [itra_pkg::BASE_W-1:0]  base;
        logic                         ptr;
        int                           pick;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(5))
                0: value = $urandom_range(0, 20);
                1: value = {1'b1, {(itra_pkg::VALUE_W-1){1'b0}}}
                           ^ itra_pkg::VALUE_W'($urandom_range(0, 3));
                2: value = ~itra_pkg::VALUE_W'($urandom_range(0, 3));
                3: value = $urandom >> $urandom_range(itra_pkg::VALUE_W - 1);
                default: value = $urandom;
            endcase
            if ($urandom_range(9) == 0)
            begin
                pick = $urandom_range(16);
                base = (pick < 2) ? itra_pkg::BASE_W'(pick) : itra_pkg::BASE_W'(pick + 15);
            end
            else
            begin
                base = itra_pkg::BASE_W'($urandom_range(2, 16));
            end
            ptr = ($urandom_range(7) == 0);
            queue_number(value, base, 1'($urandom_range(1)), ptr);
            made++;
        end
    endtask

    task automatic wait_drained();
        while (pending_numbers.size() != 0 || number_if.valid)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_if.valid        <= 1'b0;
            number_if.value        <= '0;
            number_if.base         <= '0;
            number_if.is_signed    <= 1'b0;
            number_if.pointer_mode <= 1'b0;
        end
        else
        begin
            if (number_if.valid && number_if.ready)
            begin
                next_word.value = number_if.value;
                next_word.base = number_if.base;
                next_word.sgn = number_if.is_signed;
                next_word.ptr = number_if.pointer_mode;
                text_chars = predict_text(next_word);
                words_taken++;
                if (text_chars == 0)
                begin
                    silent_words++;
                end
                if (next_word.ptr)
                begin
                    pointer_words++;
                end
            end
            if (!number_if.valid || number_if.ready)
            begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_numbers.pop_front();
                    number_if.valid        <= 1'b1;
                    number_if.value        <= next_word.value;
                    number_if.base         <= next_word.base;
                    number_if.is_signed    <= next_word.sgn;
                    number_if.pointer_mode <= next_word.ptr;
                end
                else
                begin
                    number_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_if.ready <= 1'b0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch("word with nothing expected", 32'(text_if.char_out),
                                    32'(0));
                end
                else
                begin
                    oldest_char = expected_text.pop_front();
                    if (text_if.char_out !== oldest_char.ch)
                    begin
                        report_mismatch("char_out", 32'(text_if.char_out),
                                        32'(oldest_char.ch));
                    end
                    if (text_if.last !== oldest_char.last)
                    begin
                        report_mismatch("last", 32'(text_if.last), 32'(oldest_char.last));
                    end
                    chars_checked++;
                end
            end
            text_if.ready <= !hold_text && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The output side holds off for a long stretch so that the block stalls and refuses input.
    initial
    begin
        hold_text = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_text <= 1'b1;
        repeat (400) @(posedge clk);
        hold_text <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        number_if.valid = 1'b0;
        number_if.value = '0;
        number_if.base = '0;
        number_if.is_signed = 1'b0;
        number_if.pointer_mode = 1'b0;
        text_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        words_taken = 0;
        silent_words = 0;
        pointer_words = 0;
        chars_checked = 0;
        hold_go = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        queue_number(32'h0000_0000, 5'd10, 1'b0, 1'b0);
        queue_number(32'h0000_0000, 5'd10, 1'b1, 1'b0);
        queue_number(32'h0000_0000, 5'd0, 1'b1, 1'b1);
        queue_number(32'hffff_ffff, 5'd2, 1'b0, 1'b0);
        queue_number(32'hffff_ffff, 5'd16, 1'b1, 1'b0);
        queue_number(32'h8000_0000, 5'd2, 1'b1, 1'b0);
        queue_number(32'h8000_0000, 5'd10, 1'b1, 1'b0);
        queue_number(32'h8000_0000, 5'd10, 1'b0, 1'b0);
        queue_number(32'h7fff_ffff, 5'd10, 1'b1, 1'b0);
        queue_number(32'hffff_ffff, 5'd10, 1'b0, 1'b0);
        queue_number(32'hdead_beef, 5'd16, 1'b0, 1'b0);
        queue_number(32'hdead_beef, 5'd16, 1'b1, 1'b0);
        queue_number(32'hffff_ffff, 5'd3, 1'b0, 1'b0);
        queue_number(32'h0000_0fff, 5'd7, 1'b1, 1'b0);
        queue_number(32'h1234_5678, 5'd8, 1'b0, 1'b0);
        queue_number(32'h0000_00ff, 5'd12, 1'b0, 1'b0);
        queue_number(32'hffff_ffff, 5'd31, 1'b1, 1'b1);
        queue_number(32'h0000_abcd, 5'd5, 1'b0, 1'b1);
        queue_number(32'h0000_0001, 5'd0, 1'b0, 1'b0);
        queue_number(32'h0000_0001, 5'd1, 1'b1, 1'b0);
        queue_number(32'h0000_0001, 5'd17, 1'b0, 1'b0);
        queue_number(32'h0000_0001, 5'd31, 1'b1, 1'b0);
        queue_number(32'hffff_ff80, 5'd15, 1'b1, 1'b0);
        wait_drained();

        hold_go = 1'b1;
        queue_random_numbers(50);
        wait_drained();

        send_idle_pct = 74;
        queue_random_numbers(50);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 74;
        queue_random_numbers(50);
        wait_drained();

        send_idle_pct = 9;
        recv_stall_pct = 9;
        queue_random_numbers(50);
        wait_drained();

        recv_stall_pct = 0;
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            report_mismatch("characters never delivered", 32'(expected_text.size()), 32'(0));
        end

        $display("Converted %0d numbers (%0d with a bad base, %0d in pointer mode), %0d chars.",
                 words_taken, silent_words, pointer_words, chars_checked);
        $display("Ran four idle patterns and one long output stall; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/itra_pkg.sv
rtl/core/itra_in_if.sv
rtl/core/itra_out_if.sv
rtl/core/itra_ctrl.sv
rtl/core/itra_dp.sv
rtl/core/integer_to_radix_ascii.sv
rtl/core/itra_checker.sv
tb/sv/integer_to_radix_ascii_test.sv
